// ===== sv/tn_pkg.sv =====
// tn_pkg: shared widths, types and constants of the triangle unit normal pipeline
// no dependencies; used by every other file through scoped names
`default_nettype none
package tn_pkg;

  localparam int LANES      = 3;
  localparam int ALIGN_BITS = 31;
  localparam int SQ_BITS    = 2 * ALIGN_BITS;
  localparam int SUM_BITS   = 64;
  localparam int ROOT_BITS  = 32;
  localparam int UNIT_SHIFT = 30;
  localparam int QUO_BITS   = 31;
  localparam int NUM_BITS   = ALIGN_BITS + UNIT_SHIFT + 1;
  localparam int OUT_BITS   = 32;
  localparam int DIV_SIDE   = LANES + 1;
  localparam int ROOT_SIDE  = LANES * ALIGN_BITS + DIV_SIDE;

  typedef logic [ALIGN_BITS-1:0] align_t;
  typedef logic [QUO_BITS-1:0]   quo_t;
  typedef logic [ROOT_BITS-1:0]  root_t;
  typedef logic [SUM_BITS-1:0]   sum_t;

  localparam quo_t UNIT_ONE = quo_t'(1) << UNIT_SHIFT;

endpackage
`default_nettype wire

// ===== sv/tn_if.sv =====
// tn_if: valid/ready channel interfaces for vertex requests and normal results
// depends on tn_pkg for the result width
`default_nettype none
interface tn_vtx_if #(parameter int COORD_BITS = 24) ();
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] a_x, a_y, a_z;
  logic signed [COORD_BITS-1:0] b_x, b_y, b_z;
  logic signed [COORD_BITS-1:0] c_x, c_y, c_z;

  modport source(output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
  modport sink(input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface tn_nrm_if ();
  logic valid;
  logic ready;
  logic signed [tn_pkg::OUT_BITS-1:0] n_x, n_y, n_z;
  logic degenerate;

  modport source(output valid, n_x, n_y, n_z, degenerate, input ready);
  modport sink(input valid, n_x, n_y, n_z, degenerate, output ready);
endinterface
`default_nettype wire

// ===== sv/tn_cross.sv =====
// tn_cross: edges, exact cross product and sign/magnitude split, three stages
// depends on tn_pkg
`default_nettype none
module tn_cross #(
  parameter int COORD_BITS = 24
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic valid_in,
  input  wire logic signed [COORD_BITS-1:0] va [tn_pkg::LANES],
  input  wire logic signed [COORD_BITS-1:0] vb [tn_pkg::LANES],
  input  wire logic signed [COORD_BITS-1:0] vc [tn_pkg::LANES],
  output logic valid_out,
  output logic [2*(COORD_BITS+1):0] mag [tn_pkg::LANES],
  output logic [tn_pkg::LANES-1:0] neg
);
  localparam int EW = COORD_BITS + 1;
  localparam int PW = 2 * EW;
  localparam int QW = PW + 1;

  logic v1, v2;
  logic signed [EW-1:0] e1 [tn_pkg::LANES];
  logic signed [EW-1:0] e2 [tn_pkg::LANES];
  logic signed [PW-1:0] p [2*tn_pkg::LANES];
  logic signed [QW-1:0] q [tn_pkg::LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      v1 <= valid_in;
      v2 <= v1;
      valid_out <= v2;
    end
  end

  // q = (p0 - p1, p2 - p3, p4 - p5)
  always_comb begin
    for (int i = 0; i < tn_pkg::LANES; i++) begin
      q[i] = QW'(p[2*i]) - QW'(p[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < tn_pkg::LANES; i++) begin
        e1[i] <= EW'(va[i]) - EW'(vb[i]);
        e2[i] <= EW'(vb[i]) - EW'(vc[i]);
      end
      p[0] <= e1[1] * e2[2];
      p[1] <= e1[2] * e2[1];
      p[2] <= e1[2] * e2[0];
      p[3] <= e1[0] * e2[2];
      p[4] <= e1[0] * e2[1];
      p[5] <= e1[1] * e2[0];
      for (int i = 0; i < tn_pkg::LANES; i++) begin
        neg[i] <= q[i][QW-1];
        mag[i] <= q[i][QW-1] ? QW'(-q[i]) : QW'(q[i]);
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/tn_align.sv =====
// tn_align: common alignment of the magnitudes to 31 bits, squares and sum, four stages
// depends on tn_pkg
`default_nettype none
module tn_align #(
  parameter int MAG_BITS = 51
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic valid_in,
  input  wire logic [MAG_BITS-1:0] mag [tn_pkg::LANES],
  input  wire logic [tn_pkg::LANES-1:0] neg_in,
  output logic valid_out,
  output tn_pkg::sum_t sum,
  output tn_pkg::align_t r [tn_pkg::LANES],
  output logic [tn_pkg::LANES-1:0] neg_out,
  output logic degen_out
);
  localparam int LW  = $clog2(MAG_BITS + 1);
  localparam int SHW = MAG_BITS + tn_pkg::ALIGN_BITS;

  logic v1, v2, v3;
  logic [MAG_BITS-1:0] mag1 [tn_pkg::LANES];
  logic [tn_pkg::LANES-1:0] neg1, neg2, neg3;
  logic [LW-1:0] lb1, lb_c;
  logic [MAG_BITS-1:0] any;
  tn_pkg::align_t r2 [tn_pkg::LANES];
  tn_pkg::align_t r3 [tn_pkg::LANES];
  logic [tn_pkg::SQ_BITS-1:0] sq3 [tn_pkg::LANES];
  logic degen2, degen3;
  logic [SHW-1:0] sh [tn_pkg::LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      v1 <= valid_in;
      v2 <= v1;
      v3 <= v2;
      valid_out <= v3;
    end
  end

  // bit length of the largest magnitude
  always_comb begin
    any = mag[0] | mag[1] | mag[2];
    lb_c = '0;
    for (int b = 0; b < MAG_BITS; b++) begin
      if (any[b]) lb_c = LW'(b + 1);
    end
  end

  // mag * 2^(31 - lb), truncating when lb exceeds 31
  always_comb begin
    for (int i = 0; i < tn_pkg::LANES; i++) begin
      sh[i] = {mag1[i], {tn_pkg::ALIGN_BITS{1'b0}}} >> lb1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1 <= mag;
      neg1 <= neg_in;
      lb1  <= lb_c;
      for (int i = 0; i < tn_pkg::LANES; i++) begin
        r2[i] <= sh[i][tn_pkg::ALIGN_BITS-1:0];
      end
      neg2   <= neg1;
      degen2 <= (lb1 == '0);
      for (int i = 0; i < tn_pkg::LANES; i++) begin
        sq3[i] <= r2[i] * r2[i];
      end
      r3     <= r2;
      neg3   <= neg2;
      degen3 <= degen2;
      sum <= tn_pkg::SUM_BITS'(sq3[0]) + tn_pkg::SUM_BITS'(sq3[1])
           + tn_pkg::SUM_BITS'(sq3[2]);
      r         <= r3;
      neg_out   <= neg3;
      degen_out <= degen3;
    end
  end
endmodule
`default_nettype wire

// ===== sv/tn_isqrt.sv =====
// tn_isqrt: pipelined integer square root, one result bit per stage, 32 stages
// depends on tn_pkg; sideband data travels alongside
`default_nettype none
module tn_isqrt #(
  parameter int SIDE_W = 97
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic valid_in,
  input  wire tn_pkg::sum_t radicand,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic valid_out,
  output tn_pkg::root_t root,
  output logic [SIDE_W-1:0] side_out
);
  localparam int N = tn_pkg::ROOT_BITS;

  tn_pkg::sum_t x_q [N];
  tn_pkg::sum_t res_q [N];
  logic [SIDE_W-1:0] side_q [N];
  logic [N-1:0] v_q;

  tn_pkg::sum_t x_prev [N];
  tn_pkg::sum_t res_prev [N];
  logic [SIDE_W-1:0] side_prev [N];
  tn_pkg::sum_t t [N];
  tn_pkg::sum_t x_nx [N];
  tn_pkg::sum_t res_nx [N];
  tn_pkg::sum_t stage_bit [N];

  always_comb begin
    x_prev[0]    = radicand;
    res_prev[0]  = '0;
    side_prev[0] = side_in;
    for (int k = 1; k < N; k++) begin
      x_prev[k]    = x_q[k-1];
      res_prev[k]  = res_q[k-1];
      side_prev[k] = side_q[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < N; k++) begin
      stage_bit[k] = tn_pkg::SUM_BITS'(1) << (tn_pkg::SUM_BITS - 2 - 2 * k);
      t[k] = res_prev[k] + stage_bit[k];
      if (x_prev[k] >= t[k]) begin
        x_nx[k]   = x_prev[k] - t[k];
        res_nx[k] = (res_prev[k] >> 1) + stage_bit[k];
      end else begin
        x_nx[k]   = x_prev[k];
        res_nx[k] = res_prev[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[N-2:0], valid_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_q    <= x_nx;
      res_q  <= res_nx;
      side_q <= side_prev;
    end
  end

  // a zero length divides by one
  assign root = (res_q[N-1] == '0) ? tn_pkg::root_t'(1)
                                   : res_q[N-1][tn_pkg::ROOT_BITS-1:0];
  assign side_out  = side_q[N-1];
  assign valid_out = v_q[N-1];
endmodule
`default_nettype wire

// ===== sv/tn_div.sv =====
// tn_div: three-lane pipelined restoring divider with rounding, one quotient bit per stage
// depends on tn_pkg; sideband data travels alongside
`default_nettype none
module tn_div #(
  parameter int SIDE_W = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic valid_in,
  input  wire tn_pkg::root_t len,
  input  wire tn_pkg::align_t r [tn_pkg::LANES],
  input  wire logic [SIDE_W-1:0] side_in,
  output logic valid_out,
  output tn_pkg::quo_t quot [tn_pkg::LANES],
  output logic [SIDE_W-1:0] side_out
);
  localparam int N  = tn_pkg::QUO_BITS;
  localparam int NB = tn_pkg::NUM_BITS;

  logic [NB-1:0] rem_q [N][tn_pkg::LANES];
  tn_pkg::quo_t quo_q [N][tn_pkg::LANES];
  tn_pkg::root_t len_q [N];
  logic [SIDE_W-1:0] side_q [N];
  logic [N-1:0] v_q;

  logic [NB-1:0] rem_prev [N][tn_pkg::LANES];
  tn_pkg::quo_t quo_prev [N][tn_pkg::LANES];
  tn_pkg::root_t len_prev [N];
  logic [SIDE_W-1:0] side_prev [N];
  logic [NB-1:0] rem_nx [N][tn_pkg::LANES];
  tn_pkg::quo_t quo_nx [N][tn_pkg::LANES];
  logic [NB:0] dvs [N];
  logic ge [N][tn_pkg::LANES];

  // numerator r * 2^30 + len / 2 for round half up
  always_comb begin
    for (int i = 0; i < tn_pkg::LANES; i++) begin
      rem_prev[0][i] = (NB'(r[i]) << tn_pkg::UNIT_SHIFT) + NB'(len >> 1);
      quo_prev[0][i] = '0;
    end
    len_prev[0]  = len;
    side_prev[0] = side_in;
    for (int k = 1; k < N; k++) begin
      rem_prev[k]  = rem_q[k-1];
      quo_prev[k]  = quo_q[k-1];
      len_prev[k]  = len_q[k-1];
      side_prev[k] = side_q[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < N; k++) begin
      dvs[k] = (NB + 1)'(len_prev[k]) << (N - 1 - k);
      for (int i = 0; i < tn_pkg::LANES; i++) begin
        ge[k][i] = ({1'b0, rem_prev[k][i]} >= dvs[k]);
        rem_nx[k][i] = ge[k][i] ? (rem_prev[k][i] - dvs[k][NB-1:0]) : rem_prev[k][i];
        quo_nx[k][i] = {quo_prev[k][i][N-2:0], ge[k][i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[N-2:0], valid_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q  <= rem_nx;
      quo_q  <= quo_nx;
      len_q  <= len_prev;
      side_q <= side_prev;
    end
  end

  assign quot      = quo_q[N-1];
  assign side_out  = side_q[N-1];
  assign valid_out = v_q[N-1];
endmodule
`default_nettype wire

// ===== sv/triangle_unit_normal_top.sv =====
// triangle_unit_normal_top: unit face normal of a triangle, fully pipelined
// depends on tn_pkg, tn_if, tn_cross, tn_align, tn_isqrt, tn_div
//
//  channel    role    modport           payload
//  vertices   input   tn_vtx_if.sink    a_x..c_z, signed Q12.12 vertex coordinates
//  normal     output  tn_nrm_if.source  n_x, n_y, n_z signed Q2.30, degenerate flag
//
// one request per cycle while not stalled; in order: cross product, align and square,
// square root (one root bit a stage), division (one quotient bit a stage), output
// reset is synchronous on rst and clears only valid bits; payload registers are not reset
// the whole pipeline advances together; it freezes only while the output register holds
// a result that is not taken, so nothing is dropped or repeated
`default_nettype none
module triangle_unit_normal_top #(
  parameter int COORD_BITS = 24
) (
  input wire logic clk,
  input wire logic rst,
  tn_vtx_if.sink   vertices,
  tn_nrm_if.source normal
);
  localparam int MAG_BITS = 2 * (COORD_BITS + 1) + 1;
  localparam int AB = tn_pkg::ALIGN_BITS;

  // global advance: output register empty or being drained
  logic en;
  logic out_valid;

  logic signed [COORD_BITS-1:0] va [tn_pkg::LANES];
  logic signed [COORD_BITS-1:0] vb [tn_pkg::LANES];
  logic signed [COORD_BITS-1:0] vc [tn_pkg::LANES];

  logic cr_valid;
  logic [MAG_BITS-1:0] cr_mag [tn_pkg::LANES];
  logic [tn_pkg::LANES-1:0] cr_neg;

  logic al_valid;
  tn_pkg::sum_t al_sum;
  tn_pkg::align_t al_r [tn_pkg::LANES];
  logic [tn_pkg::LANES-1:0] al_neg;
  logic al_degen;

  logic sq_valid;
  tn_pkg::root_t sq_root;
  logic [tn_pkg::ROOT_SIDE-1:0] sq_side;
  tn_pkg::align_t sq_r [tn_pkg::LANES];

  logic dv_valid;
  tn_pkg::quo_t dv_quot [tn_pkg::LANES];
  logic [tn_pkg::DIV_SIDE-1:0] dv_side;

  tn_pkg::quo_t mag_c [tn_pkg::LANES];
  logic signed [tn_pkg::OUT_BITS-1:0] n_c [tn_pkg::LANES];

  assign en = !out_valid || normal.ready;
  assign vertices.ready = en;

  assign va[0] = vertices.a_x;
  assign va[1] = vertices.a_y;
  assign va[2] = vertices.a_z;
  assign vb[0] = vertices.b_x;
  assign vb[1] = vertices.b_y;
  assign vb[2] = vertices.b_z;
  assign vc[0] = vertices.c_x;
  assign vc[1] = vertices.c_y;
  assign vc[2] = vertices.c_z;

  // edges and exact cross product
  tn_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk(clk), .rst(rst), .en(en), .valid_in(vertices.valid),
    .va(va), .vb(vb), .vc(vc),
    .valid_out(cr_valid), .mag(cr_mag), .neg(cr_neg)
  );

  // shift all magnitudes so the largest has 31 bits, then sum of squares
  tn_align #(.MAG_BITS(MAG_BITS)) u_align (
    .clk(clk), .rst(rst), .en(en), .valid_in(cr_valid),
    .mag(cr_mag), .neg_in(cr_neg),
    .valid_out(al_valid), .sum(al_sum), .r(al_r), .neg_out(al_neg), .degen_out(al_degen)
  );

  // length; aligned components, signs and flag ride along
  tn_isqrt #(.SIDE_W(tn_pkg::ROOT_SIDE)) u_isqrt (
    .clk(clk), .rst(rst), .en(en), .valid_in(al_valid),
    .radicand(al_sum),
    .side_in({al_degen, al_neg, al_r[2], al_r[1], al_r[0]}),
    .valid_out(sq_valid), .root(sq_root), .side_out(sq_side)
  );

  assign sq_r[0] = sq_side[AB-1:0];
  assign sq_r[1] = sq_side[2*AB-1:AB];
  assign sq_r[2] = sq_side[3*AB-1:2*AB];

  // component / length, rounded half up on the magnitude
  tn_div #(.SIDE_W(tn_pkg::DIV_SIDE)) u_div (
    .clk(clk), .rst(rst), .en(en), .valid_in(sq_valid),
    .len(sq_root), .r(sq_r),
    .side_in(sq_side[tn_pkg::ROOT_SIDE-1:3*AB]),
    .valid_out(dv_valid), .quot(dv_quot), .side_out(dv_side)
  );

  // clamp to one and restore the sign of each cross component
  always_comb begin
    for (int i = 0; i < tn_pkg::LANES; i++) begin
      mag_c[i] = (dv_quot[i] > tn_pkg::UNIT_ONE) ? tn_pkg::UNIT_ONE : dv_quot[i];
      n_c[i] = dv_side[i] ? -tn_pkg::OUT_BITS'(mag_c[i]) : tn_pkg::OUT_BITS'(mag_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      normal.n_x <= n_c[0];
      normal.n_y <= n_c[1];
      normal.n_z <= n_c[2];
      normal.degenerate <= dv_side[tn_pkg::LANES];
    end
  end

  assign normal.valid = out_valid;
endmodule
`default_nettype wire

// ===== sv/tn_check.sv =====
// tn_check: port-level assertions for triangle_unit_normal_top, bound to the top level
// depends on tn_pkg
`default_nettype none
module tn_check (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic signed [tn_pkg::OUT_BITS-1:0] n_x,
  input wire logic signed [tn_pkg::OUT_BITS-1:0] n_y,
  input wire logic signed [tn_pkg::OUT_BITS-1:0] n_z,
  input wire logic degenerate
);
  localparam logic signed [tn_pkg::OUT_BITS-1:0] ONE = 32'sd1073741824;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (n_x == '0 && n_y == '0 && n_z == '0))
    else $error("degenerate result with nonzero normal");

  a_normal_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !degenerate) |-> (n_x != '0 || n_y != '0 || n_z != '0))
    else $error("zero normal without degenerate flag");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (n_x <= ONE && n_x >= -ONE && n_y <= ONE && n_y >= -ONE
                   && n_z <= ONE && n_z >= -ONE))
    else $error("normal component beyond one");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(n_x) && $stable(n_y)
                                   && $stable(n_z) && $stable(degenerate)))
    else $error("stalled result changed");
endmodule

bind triangle_unit_normal_top tn_check u_check (
  .clk(clk), .rst(rst),
  .out_valid(normal.valid), .out_ready(normal.ready),
  .n_x(normal.n_x), .n_y(normal.n_y), .n_z(normal.n_z),
  .degenerate(normal.degenerate)
);
`default_nettype wire
